>>> sv/rtml_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rtml_pkg
// Shared types and constants for the recency table merge and lookup block.
// ---------------------------------------------------------------------------
package rtml_pkg;
  localparam int TABLE_ENTRIES_DEF     = 16;
  localparam int FRIENDS_PER_ENTRY_DEF = 16;
  localparam int MAX_STAGED_DEF        = 5;
  localparam logic [15:0] END_MARK     = 16'hFFFF;
  localparam logic [4:0]  CODE_SAT     = 5'd31;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_STAGE  = 3'd1,
    CMD_FRIEND = 3'd2,
    CMD_COMMIT = 3'd3,
    CMD_LOOKUP = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  // Name equality up to and including the first end marker.
  function automatic logic names_equal(input logic [127:0] a, input logic [127:0] b);
    logic eq;
    logic done;
    eq = 1'b1;
    done = 1'b0;
    for (int c = 0; c < 8; c++) begin
      if (!done) begin
        if (a[16*c +: 16] != b[16*c +: 16]) begin
          eq = 1'b0;
          done = 1'b1;
        end else if (a[16*c +: 16] == END_MARK) begin
          done = 1'b1;
        end
      end
    end
    return eq;
  endfunction
endpackage
`default_nettype wire

>>> sv/rtml_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rtml_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module rtml_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/recency_table_merge_and_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// recency_table_merge_and_lookup
// Recency-ordered roster table with staged merge and id lookup.
// ---------------------------------------------------------------------------
// Channel | dir | payload
// s_*     | in  | command, slot_index, friend_slot, name, owner, friend
// m_*     | out | status, match_code, name, owner, friend, valid
// Entry headers live in flip-flops, friend lists in two RAMs (active and
// shadow bank) so commit rebuilds the shadow and swaps. After reset the
// friend RAMs are swept clear before any request is taken. One request
// is in work at a time; the result register holds while m_tready is low.
// ---------------------------------------------------------------------------
module recency_table_merge_and_lookup #(
  parameter int TABLE_ENTRIES     = rtml_pkg::TABLE_ENTRIES_DEF,
  parameter int FRIENDS_PER_ENTRY = rtml_pkg::FRIENDS_PER_ENTRY_DEF,
  parameter int MAX_STAGED        = rtml_pkg::MAX_STAGED_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // command[2:0], slot_index[6:3], friend_slot[10:7], name_low[74:11],
  // name_high[138:75], owner_id[170:139], friend_value[202:171]
  input  wire logic [207:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status[0], match_code[5:1], out_name_low[69:6], out_name_high[133:70],
  // out_owner_id[165:134], out_friend[197:166], out_valid[198]
  output logic      [199:0] m_tdata
);
  localparam int E  = TABLE_ENTRIES;
  localparam int F  = FRIENDS_PER_ENTRY;
  localparam int S  = MAX_STAGED;
  localparam int EW = $clog2(E);
  localparam int FW = (F > 1) ? $clog2(F) : 1;
  localparam int SW = $clog2(S + 1);
  localparam int TD = E * F;
  localparam int TAW = $clog2(TD);
  localparam int SD = S * F;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int EC = $clog2(E + 1);

  typedef enum logic [10:0] {
    ST_INIT   = 11'b00000000001,
    ST_IDLE   = 11'b00000000010,
    ST_SCLR   = 11'b00000000100,
    ST_RDW    = 11'b00000001000,
    ST_LKUP   = 11'b00000010000,
    ST_LKW    = 11'b00000100000,
    ST_DROP   = 11'b00001000000,
    ST_PLAN   = 11'b00010000000,
    ST_COPY   = 11'b00100000000,
    ST_COPYW  = 11'b01000000000,
    ST_OUT    = 11'b10000000000
  } state_t;

  state_t state;

  // Headers.
  logic [127:0] t_name [E];
  logic [31:0]  t_own  [E];
  logic [127:0] s_name [S];
  logic [31:0]  s_own  [S];
  logic [SW-1:0] scount;
  logic          bank;

  // Request register.
  logic [2:0]   r_cmd;
  logic [3:0]   r_slot;
  logic [31:0]  r_owner;
  logic [127:0] r_name;

  // Counters and plan.
  logic [TAW:0] cnt;
  logic [EW-1:0] src_idx [E];
  logic          src_stg [E];
  logic          src_ok  [E];
  logic [EC-1:0] pk;
  logic [EW:0]   pi;
  logic [SW-1:0] di;
  logic [E-1:0]  alive;
  logic [EW:0]   ce;
  logic [FW:0]   cf;
  logic          ownhit;

  // Friend RAMs: two table banks and one staged RAM.
  logic         tw0, tw1;
  logic [TAW-1:0] twa, tra;
  logic [31:0]  twd, trd0, trd1;
  logic         sw_e;
  logic [SAW-1:0] swa, sra;
  logic [31:0]  swd, srd;

  rtml_ram #(.WIDTH(32), .DEPTH(TD)) u_tab0 (
    .clk(clk), .we(tw0), .waddr(twa), .wdata(twd), .raddr(tra), .rdata(trd0));
  rtml_ram #(.WIDTH(32), .DEPTH(TD)) u_tab1 (
    .clk(clk), .we(tw1), .waddr(twa), .wdata(twd), .raddr(tra), .rdata(trd1));
  rtml_ram #(.WIDTH(32), .DEPTH(SD)) u_stg (
    .clk(clk), .we(sw_e), .waddr(swa), .wdata(swd), .raddr(sra), .rdata(srd));

  logic [31:0] trd_act;
  assign trd_act = bank ? trd1 : trd0;

  logic [2:0]  in_cmd;
  logic [3:0]  in_slot, in_fs;
  assign in_cmd  = s_tdata[2:0];
  assign in_slot = s_tdata[6:3];
  assign in_fs   = s_tdata[10:7];

  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  logic acc;
  assign acc = s_tvalid && s_tready;

  // Status of the request on the input, ignored requests report 1.
  logic in_bad;
  always_comb begin
    unique case (in_cmd)
      rtml_pkg::CMD_CLEAR, rtml_pkg::CMD_COMMIT, rtml_pkg::CMD_LOOKUP: in_bad = 1'b0;
      rtml_pkg::CMD_STAGE: in_bad = (scount >= SW'(S));
      rtml_pkg::CMD_FRIEND: in_bad = (32'(in_slot) >= 32'(scount)) ||
                                     (32'(in_fs) >= 32'(F));
      rtml_pkg::CMD_READ: in_bad = (32'(in_slot) >= 32'(E)) || (32'(in_fs) >= 32'(F));
      default: in_bad = 1'b1;
    endcase
  end

  logic own_any;
  always_comb begin
    own_any = 1'b0;
    for (int j = 0; j < E; j++) begin
      if (t_own[j] == s_tdata[170:139]) own_any = 1'b1;
    end
  end

  // Entry and friend coordinates of the copy and lookup scans.
  logic [EW-1:0] ce_i;
  logic [FW-1:0] cf_i;
  assign ce_i = ce[EW-1:0];
  assign cf_i = cf[FW-1:0];

  always_comb begin
    tw0 = 1'b0;
    tw1 = 1'b0;
    twa = cnt[TAW-1:0];
    twd = '0;
    tra = cnt[TAW-1:0];
    sw_e = 1'b0;
    swa = cnt[SAW-1:0];
    swd = '0;
    sra = cnt[SAW-1:0];
    unique case (state)
      ST_INIT: begin
        tw0 = 1'b1;
        tw1 = 1'b1;
        sw_e = (cnt < (TAW+1)'(SD));
      end
      ST_SCLR: begin
        sw_e = 1'b1;
        swa = SAW'((r_cmd == rtml_pkg::CMD_CLEAR) ? cnt :
              (TAW+1)'(scount) * (TAW+1)'(F) + cnt);
      end
      ST_IDLE: begin
        if (acc && in_cmd == rtml_pkg::CMD_FRIEND && !in_bad) begin
          sw_e = 1'b1;
          swa  = SAW'(32'(in_slot) * F + 32'(in_fs));
          swd  = s_tdata[202:171];
        end
        tra = TAW'(32'(in_slot) * F + 32'(in_fs));
      end
      ST_LKUP: begin
        tra = TAW'(32'(ce_i) * F + 32'(cf_i));
      end
      ST_COPY, ST_COPYW: begin
        tra = TAW'(32'(src_idx[ce_i]) * F + 32'(cf_i));
        sra = SAW'(32'(src_idx[ce_i]) * F + 32'(cf_i));
      end
      default: begin
      end
    endcase
    // Write side of the copy runs in ST_COPYW, in the cycle after the read in ST_COPY.
    if (state == ST_COPYW) begin
      twa = TAW'(32'(ce_i) * F + 32'(cf_i));
      twd = !src_ok[ce_i] ? 32'd0 : (src_stg[ce_i] ? srd : trd_act);
      if (bank) tw0 = 1'b1; else tw1 = 1'b1;
    end
  end

  // Match of table entry j against staged entry di, and the last such match.
  logic [E-1:0] keyhit;
  logic [E-1:0] lasthit;
  always_comb begin
    for (int j = 0; j < E; j++) begin
      keyhit[j] = rtml_pkg::names_equal(t_name[j], s_name[di]) &&
                  (t_own[j] == s_own[di]);
    end
    for (int j = 0; j < E; j++) begin
      lasthit[j] = keyhit[j] && ((keyhit >> (j + 1)) == '0);
    end
  end

  logic [199:0] res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      cnt      <= '0;
      scount   <= '0;
      bank     <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < E; i++) begin
        t_name[i] <= {112'd0, rtml_pkg::END_MARK};
        t_own[i]  <= '0;
      end
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == (TAW+1)'(TD - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (acc) begin
            r_cmd   <= in_cmd;
            r_slot  <= in_slot;
            r_owner <= s_tdata[170:139];
            r_name  <= s_tdata[138:11];
            res     <= {199'd0, in_bad};
            cnt     <= '0;
            unique case (in_cmd)
              rtml_pkg::CMD_CLEAR: state <= ST_SCLR;
              rtml_pkg::CMD_STAGE: state <= in_bad ? ST_OUT : ST_SCLR;
              rtml_pkg::CMD_FRIEND: state <= ST_OUT;
              rtml_pkg::CMD_COMMIT: begin
                di <= '0;
                for (int j = 0; j < E; j++)
                  alive[j] <= (t_name[j][15:0] != rtml_pkg::END_MARK);
                state <= (scount == '0) ? ST_PLAN : ST_DROP;
                pk <= '0;
                pi <= '0;
              end
              rtml_pkg::CMD_LOOKUP: begin
                ownhit <= own_any;
                ce <= '0;
                cf <= '0;
                state <= ST_LKUP;
              end
              rtml_pkg::CMD_READ: state <= in_bad ? ST_OUT : ST_RDW;
              default: state <= ST_OUT;
            endcase
          end
        end
        ST_SCLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (TAW+1)'(((r_cmd == rtml_pkg::CMD_CLEAR) ? SD : F) - 1)) begin
            state <= ST_OUT;
            if (r_cmd == rtml_pkg::CMD_CLEAR) scount <= '0;
            else begin
              s_name[scount] <= r_name;
              s_own[scount]  <= r_owner;
              scount <= scount + 1'b1;
            end
          end
        end
        ST_RDW: begin
          res[69:6]    <= t_name[r_slot[EW-1:0]][63:0];
          res[133:70]  <= t_name[r_slot[EW-1:0]][127:64];
          res[165:134] <= t_own[r_slot[EW-1:0]];
          res[197:166] <= trd_act;
          res[198]     <= (t_name[r_slot[EW-1:0]][15:0] != rtml_pkg::END_MARK);
          state <= ST_OUT;
        end
        ST_LKUP: begin
          // Friend word (ce, cf) is read here; its compare follows in ST_LKW.
          state <= ST_LKW;
        end
        ST_LKW: begin
          if (ownhit) begin
            res[5:1] <= 5'd1;
            state <= ST_OUT;
          end else if (trd_act == r_owner) begin
            res[5:1] <= (32'(ce) + 2 > 31) ? rtml_pkg::CODE_SAT : 5'(32'(ce) + 2);
            state <= ST_OUT;
          end else if (cf == (FW+1)'(F - 1) && ce == (EW+1)'(E - 1)) begin
            state <= ST_OUT;
          end else begin
            if (cf == (FW+1)'(F - 1)) begin
              cf <= '0;
              ce <= ce + 1'b1;
            end else begin
              cf <= cf + 1'b1;
            end
            state <= ST_LKUP;
          end
        end
        ST_DROP: begin
          // Only the last matching old entry for staged entry di is dropped.
          for (int j = 0; j < E; j++) begin
            if (lasthit[j]) alive[j] <= 1'b0;
          end
          if (di == scount - 1'b1) state <= ST_PLAN;
          di <= di + 1'b1;
        end
        ST_PLAN: begin
          // Build the source map one step a cycle.
          if (32'(pk) < 32'(scount) && pi == '0) begin
            src_idx[pk[EW-1:0]] <= EW'(pk);
            src_stg[pk[EW-1:0]] <= 1'b1;
            src_ok[pk[EW-1:0]]  <= 1'b1;
            pk <= pk + 1'b1;
          end else if (pk < EC'(E)) begin
            if (pi < (EW+1)'(E)) begin
              if (alive[pi[EW-1:0]]) begin
                src_idx[pk[EW-1:0]] <= pi[EW-1:0];
                src_stg[pk[EW-1:0]] <= 1'b0;
                src_ok[pk[EW-1:0]]  <= 1'b1;
                pk <= pk + 1'b1;
              end
              pi <= pi + 1'b1;
            end else begin
              src_ok[pk[EW-1:0]] <= 1'b0;
              src_idx[pk[EW-1:0]] <= '0;
              src_stg[pk[EW-1:0]] <= 1'b0;
              pk <= pk + 1'b1;
            end
          end else begin
            ce <= '0;
            cf <= '0;
            state <= ST_COPY;
          end
        end
        ST_COPY: state <= ST_COPYW;
        ST_COPYW: begin
          if (cf == (FW+1)'(F - 1)) begin
            cf <= '0;
            if (ce == (EW+1)'(E - 1)) begin
              // Swap in the new headers and bank.
              for (int k = 0; k < E; k++) begin
                if (!src_ok[k]) begin
                  t_name[k] <= {112'd0, rtml_pkg::END_MARK};
                  t_own[k]  <= '0;
                end else if (src_stg[k]) begin
                  t_name[k] <= s_name[SW'(src_idx[k])];
                  t_own[k]  <= s_own[SW'(src_idx[k])];
                end else begin
                  t_name[k] <= t_name[src_idx[k]];
                  t_own[k]  <= t_own[src_idx[k]];
                end
              end
              bank <= ~bank;
              scount <= '0;
              state <= ST_OUT;
            end else begin
              ce <= ce + 1'b1;
              state <= ST_COPY;
            end
          end else begin
            cf <= cf + 1'b1;
            state <= ST_COPY;
          end
        end
        ST_OUT: begin
          m_tvalid <= 1'b1;
          m_tdata  <= res;
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_noacc_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("ready while busy");
  a_scount: assert property (@(posedge clk) disable iff (rst)
    scount <= SW'(S)) else $error("staged count overflow");
  a_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |=> m_tvalid) else $error("result lost");
`endif
endmodule
`default_nettype wire
